// File: rtl/fbc_pkg.sv
`default_nettype none

package fbc_pkg;

  localparam int PLANE_W   = 64;
  localparam int FIELD_W   = 16;
  localparam int REG_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  // d carries 2^14 scaling, doubled
  localparam int D_SHIFT   = 15;

  localparam logic [1:0] VERDICT_INSIDE       = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECTING = 2'd1;
  localparam logic [1:0] VERDICT_OUTSIDE      = 2'd2;

  typedef struct packed {
    logic outside;
    logic clipped;
  } flags_t;

endpackage

`default_nettype wire

// File: rtl/fbc_if.sv
`default_nettype none

interface fbc_box_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] min_z;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fbc_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

interface fbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/fbc_cell.sv
`default_nettype none

module fbc_cell
  import fbc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [PLANE_W-1:0]                     plane,
  input  wire logic                                   up_valid,
  output logic                                        up_ready,
  input  wire logic [2:0][COORD_BITS:0]               up_sum,
  input  wire logic [2:0][COORD_BITS:0]               up_span,
  input  wire flags_t                                 up_flags,
  output logic                                        dn_valid,
  input  wire logic                                   dn_ready,
  output logic [2:0][COORD_BITS:0]                    dn_sum,
  output logic [2:0][COORD_BITS:0]                    dn_span,
  output flags_t                                      dn_flags
);

  localparam int SUM_W  = COORD_BITS + 1;
  localparam int PROD_W = COORD_BITS + 18;
  localparam int ACC_W  = (COORD_BITS + 20 > 34) ? COORD_BITS + 20 : 34;

  // plane coefficients
  logic signed [FIELD_W-1:0] coef   [3];
  logic        [FIELD_W:0]   mag    [3];
  logic signed [FIELD_W-1:0] d_coef;

  // stage 1: products
  logic                             v1;
  logic [2:0][SUM_W-1:0]            sum1, span1;
  flags_t                           flags1;
  logic signed [PROD_W-1:0]         pm1 [3];
  logic signed [PROD_W-1:0]         pn1 [3];

  // stage 2: center distance and extent
  logic                             v2;
  logic [2:0][SUM_W-1:0]            sum2, span2;
  flags_t                           flags2;
  logic signed [ACC_W-1:0]          m2, n2;
  logic signed [ACC_W-1:0]          m2_next, n2_next;

  // stage 3: sign tests folded into the flags
  logic                             v3;
  logic [2:0][SUM_W-1:0]            sum3, span3;
  flags_t                           flags3;
  logic signed [ACC_W-1:0]          hi_sum, lo_sum;

  logic en1, en2, en3;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coef[k] = plane[k*FIELD_W +: FIELD_W];
      mag[k]  = coef[k][FIELD_W-1] ? (~{1'b1, coef[k]} + 1'b1) : {1'b0, coef[k]};
    end
    d_coef = plane[3*FIELD_W +: FIELD_W];
  end

  assign en3      = !v3 || dn_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sum1   <= up_sum;
      span1  <= up_span;
      flags1 <= up_flags;
      for (int k = 0; k < 3; k++) begin
        pm1[k] <= $signed({{(PROD_W-SUM_W){up_sum[k][SUM_W-1]}}, up_sum[k]})
                * $signed({{(PROD_W-FIELD_W){coef[k][FIELD_W-1]}}, coef[k]});
        pn1[k] <= $signed({{(PROD_W-SUM_W){up_span[k][SUM_W-1]}}, up_span[k]})
                * $signed({{(PROD_W-FIELD_W-1){1'b0}}, mag[k]});
      end
    end
  end

  always_comb begin
    m2_next = $signed({{(ACC_W-FIELD_W-D_SHIFT){d_coef[FIELD_W-1]}}, d_coef, {D_SHIFT{1'b0}}});
    n2_next = '0;
    for (int k = 0; k < 3; k++) begin
      m2_next = m2_next + $signed({{(ACC_W-PROD_W){pm1[k][PROD_W-1]}}, pm1[k]});
      n2_next = n2_next + $signed({{(ACC_W-PROD_W){pn1[k][PROD_W-1]}}, pn1[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sum2   <= sum1;
      span2  <= span1;
      flags2 <= flags1;
      m2     <= m2_next;
      n2     <= n2_next;
    end
  end

  assign hi_sum = m2 + n2;
  assign lo_sum = m2 - n2;

  always_ff @(posedge clk) begin
    if (en3) begin
      sum3           <= sum2;
      span3          <= span2;
      flags3.outside <= flags2.outside | hi_sum[ACC_W-1];
      flags3.clipped <= flags2.clipped | lo_sum[ACC_W-1];
    end
  end

  assign dn_valid = v3;
  assign dn_sum   = sum3;
  assign dn_span  = span3;
  assign dn_flags = flags3;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    v3 && !dn_ready |=> v3 && $stable(flags3))
    else $error("cell result changed while stalled");

  a_outside_sticky: assert property (@(posedge clk) disable iff (rst)
    en3 && v2 && flags2.outside |=> flags3.outside)
    else $error("outside flag lost in cell");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> up_ready)
    else $error("empty cell refused a request");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !v2 && en3 |=> !v3)
    else $error("cell produced a result from a bubble");
`endif

endmodule

`default_nettype wire

// File: rtl/frustum_box_classifier.sv
// Channel  Dir  Payload                                   Request
// box      in   min_x..min_z, max_x..max_z (signed)       box.valid && box.ready
// result   out  verdict: 0 inside, 1 intersecting, 2 out  result.valid && result.ready
// cfg      in   index (plane 0..5), data (a,b,c,d packed) cfg.valid && cfg.ready
//
// One box per cycle sustained while result.ready holds; one cell per plane,
// each cell with a product, an accumulate and a sign-test register stage.
// rst clears the valid bits and sets every plane to zero (every box inside).
// A stalled result backs up only to the nearest bubble; cfg is always ready.
`default_nettype none

module frustum_box_classifier
  import fbc_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int PLANE_COUNT = 6
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fbc_box_if.sink     box,
  fbc_verdict_if.source result,
  fbc_cfg_if.sink     cfg
);

  logic [PLANE_W-1:0] planes [REG_COUNT];

  logic                                chain_valid [PLANE_COUNT+1];
  logic                                chain_ready [PLANE_COUNT+1];
  logic [2:0][COORD_BITS:0]            chain_sum   [PLANE_COUNT+1];
  logic [2:0][COORD_BITS:0]            chain_span  [PLANE_COUNT+1];
  flags_t                              chain_flags [PLANE_COUNT+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) planes[i] <= '0;
    end else if (cfg.valid && (32'(cfg.index) < REG_COUNT)) begin
      planes[cfg.index] <= cfg.data;
    end
  end

  always_comb begin
    chain_sum[0][0]  = {box.min_x[COORD_BITS-1], box.min_x} + {box.max_x[COORD_BITS-1], box.max_x};
    chain_sum[0][1]  = {box.min_y[COORD_BITS-1], box.min_y} + {box.max_y[COORD_BITS-1], box.max_y};
    chain_sum[0][2]  = {box.min_z[COORD_BITS-1], box.min_z} + {box.max_z[COORD_BITS-1], box.max_z};
    chain_span[0][0] = {box.max_x[COORD_BITS-1], box.max_x} - {box.min_x[COORD_BITS-1], box.min_x};
    chain_span[0][1] = {box.max_y[COORD_BITS-1], box.max_y} - {box.min_y[COORD_BITS-1], box.min_y};
    chain_span[0][2] = {box.max_z[COORD_BITS-1], box.max_z} - {box.min_z[COORD_BITS-1], box.min_z};
  end

  assign chain_valid[0] = box.valid;
  assign chain_flags[0] = '0;
  assign box.ready      = chain_ready[0];

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    logic [PLANE_W-1:0] cell_plane;

    if (i < REG_COUNT) begin : g_reg
      assign cell_plane = planes[i];
    end else begin : g_zero
      assign cell_plane = '0;
    end

    fbc_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .plane    (cell_plane),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_sum   (chain_sum[i]),
      .up_span  (chain_span[i]),
      .up_flags (chain_flags[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_sum   (chain_sum[i+1]),
      .dn_span  (chain_span[i+1]),
      .dn_flags (chain_flags[i+1])
    );
  end

  assign chain_ready[PLANE_COUNT] = result.ready;
  assign result.valid             = chain_valid[PLANE_COUNT];

  always_comb begin
    if (chain_flags[PLANE_COUNT].outside) begin
      result.verdict = VERDICT_OUTSIDE;
    end else if (chain_flags[PLANE_COUNT].clipped) begin
      result.verdict = VERDICT_INTERSECTING;
    end else begin
      result.verdict = VERDICT_INSIDE;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_frustum_box_classifier.sv
`timescale 1ns / 1ps

import fbc_pkg::*;

typedef logic signed [FIELD_W-1:0] coord_t;

typedef struct packed {
  coord_t min_x;
  coord_t min_y;
  coord_t min_z;
  coord_t max_x;
  coord_t max_y;
  coord_t max_z;
} box_t;

typedef struct {
  logic [1:0] verdict;
  int         seq;
} verdict_ticket_t;

class verdict_board;
  logic [PLANE_W-1:0] coeffs [REG_COUNT];
  verdict_ticket_t    expected_q [$];
  int                 boxes_seen;
  int                 mismatches;

  function void clear_planes();
    for (int i = 0; i < REG_COUNT; i++) coeffs[i] = '0;
  endfunction

  function void set_plane(int idx, logic [PLANE_W-1:0] data);
    // slots past the six planes have no storage
    if (idx < REG_COUNT) coeffs[idx] = data;
  endfunction

  // center-extent test on doubled values, exact in 64 bits
  function logic [1:0] classify(box_t b);
    longint lo [3];
    longint hi [3];
    longint m2, n2, nk;
    logic signed [FIELD_W-1:0] f;
    logic outside, clipped;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    outside = 1'b0;
    clipped = 1'b0;
    for (int p = 0; p < REG_COUNT; p++) begin
      f  = coeffs[p][4*FIELD_W-1:3*FIELD_W];
      m2 = longint'(f) <<< D_SHIFT;
      n2 = 0;
      for (int k = 0; k < 3; k++) begin
        f  = coeffs[p][FIELD_W*k +: FIELD_W];
        nk = f;
        m2 += (lo[k] + hi[k]) * nk;
        n2 += (hi[k] - lo[k]) * ((nk < 0) ? -nk : nk);
      end
      if (m2 + n2 < 0) outside = 1'b1;
      else if (m2 - n2 < 0) clipped = 1'b1;
    end
    if (outside) return VERDICT_OUTSIDE;
    if (clipped) return VERDICT_INTERSECTING;
    return VERDICT_INSIDE;
  endfunction

  function void note_box(box_t b);
    verdict_ticket_t t;
    t.verdict = classify(b);
    t.seq     = boxes_seen;
    boxes_seen++;
    expected_q.push_back(t);
  endfunction

  function void check_verdict(logic [1:0] got);
    verdict_ticket_t t;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("verdict %0d arrived with no box outstanding", got);
      return;
    end
    t = expected_q.pop_front();
    if (got !== t.verdict) begin
      mismatches++;
      if (mismatches <= 10)
        $display("box %0d: verdict expected %0d, got %0d", t.seq, t.verdict, got);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_frustum_box_classifier;

  localparam int PLANE_COUNT    = 6;
  localparam int LATENCY        = 3 * PLANE_COUNT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int Q_ONE          = 16384;
  localparam int Q_NEG_TWO      = -32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    PLANE_NEAR, PLANE_FAR, PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM,
    SLOT_SPARE6, SLOT_SPARE7
  } plane_idx_e;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fbc_box_if     box_ch ();
  fbc_verdict_if res_ch ();
  fbc_cfg_if     cfg_ch ();

  frustum_box_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .box    (box_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  verdict_board board;
  int           burst_left   = 0;
  int           quiet_cycles = 0;
  rx_mode_e     rx_mode      = RX_OPEN;
  int unsigned  rx_left      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && box_ch.valid && box_ch.ready)
      board.note_box({box_ch.min_x, box_ch.min_y, box_ch.min_z,
                      box_ch.max_x, box_ch.max_y, box_ch.max_z});
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_verdict(res_ch.verdict);
  end

  // result backpressure: one of four stall modes, picked anew whenever rx_left runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   res_ch.ready <= 1'b1;
      RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   res_ch.ready <= (rx_left[3:0] > 4'd9);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb_frustum_box_classifier: FAIL");
        $finish;
      end
    end
  end

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic box_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.min_x = coord_t'(x0);
    b.min_y = coord_t'(y0);
    b.min_z = coord_t'(z0);
    b.max_x = coord_t'(x1);
    b.max_y = coord_t'(y1);
    b.max_z = coord_t'(z1);
    return b;
  endfunction

  // mostly well-formed boxes around the origin; some raw bit noise, some inverted axes
  function automatic box_t rand_box(int extent);
    coord_t lo [3];
    coord_t hi [3];
    coord_t tmp;
    int pick, c, h;
    pick = $urandom_range(0, 19);
    for (int k = 0; k < 3; k++) begin
      if (pick < 3) begin
        lo[k] = coord_t'($urandom);
        hi[k] = coord_t'($urandom);
      end else begin
        c = int'($urandom_range(0, 2 * extent)) - extent;
        h = $urandom_range(0, 1) ? $urandom_range(0, extent / 2) : $urandom_range(0, 64);
        lo[k] = clamp_coord(c - h);
        hi[k] = clamp_coord(c + h);
        if (pick == 3 && $urandom_range(0, 1)) begin
          tmp   = lo[k];
          lo[k] = hi[k];
          hi[k] = tmp;
        end
      end
    end
    return {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  function automatic logic [PLANE_W-1:0] tilted_plane();
    return pack_plane(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                      int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                      int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                      $urandom_range(0, 12000));
  endfunction

  task automatic send_box(input box_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        box_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    box_ch.valid <= 1'b1;
    box_ch.min_x <= b.min_x;
    box_ch.min_y <= b.min_y;
    box_ch.min_z <= b.min_z;
    box_ch.max_x <= b.max_x;
    box_ch.max_y <= b.max_y;
    box_ch.max_z <= b.max_z;
    do @(posedge clk); while (!box_ch.ready);
  endtask

  // valid stays high across back-to-back writes; end_config drops it
  task automatic write_plane(input plane_idx_e idx, input logic [PLANE_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_plane(int'(idx), data);
  endtask

  task automatic end_config();
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [PLANE_W-1:0] data);
    for (int i = 0; i < REG_COUNT; i++) write_plane(plane_idx_e'(i), data);
    end_config();
  endtask

  // axis-aligned cube |x|,|y|,|z| <= r; upper bounds use the -2.0 normal
  task automatic cube_planes(input int r);
    write_plane(PLANE_NEAR,   pack_plane(0, 0, Q_ONE, r));
    write_plane(PLANE_FAR,    pack_plane(0, 0, Q_NEG_TWO, 2 * r));
    write_plane(PLANE_LEFT,   pack_plane(Q_ONE, 0, 0, r));
    write_plane(PLANE_RIGHT,  pack_plane(Q_NEG_TWO, 0, 0, 2 * r));
    write_plane(PLANE_BOTTOM, pack_plane(0, Q_ONE, 0, r));
    write_plane(PLANE_TOP,    pack_plane(0, Q_NEG_TWO, 0, 2 * r));
    end_config();
  endtask

  task automatic run_directed();
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    send_box(mk_box(100, -50, 7, -100, 50, -7));
    send_box(mk_box(-32768, 0, 200, 32767, 0, -200));
  endtask

  task automatic run_random(input int count, input int extent);
    repeat (count) send_box(rand_box(extent));
  endtask

  // quiesce before touching the planes
  task automatic settle();
    box_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    board = new;
    board.clear_planes();
    box_ch.valid = 1'b0;
    box_ch.min_x = '0;
    box_ch.min_y = '0;
    box_ch.min_z = '0;
    box_ch.max_x = '0;
    box_ch.max_y = '0;
    box_ch.max_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // planes out of reset are all zero
    run_directed();
    run_random(100, 32767);
    settle();

    cube_planes(8000);
    run_directed();
    run_random(200, 12000);
    settle();

    for (int i = 0; i < REG_COUNT; i++) write_plane(plane_idx_e'(i), tilted_plane());
    end_config();
    run_random(200, 10000);
    settle();

    write_all(64'h8000_8000_8000_8000);
    run_directed();
    run_random(50, 32767);
    settle();

    write_all(64'h7fff_7fff_7fff_7fff);
    run_random(50, 32767);
    settle();

    // raw planes, plus writes to the unused slots that must not land anywhere
    for (int i = 0; i < REG_COUNT; i++) write_plane(plane_idx_e'(i), {$urandom, $urandom});
    write_plane(SLOT_SPARE6, {$urandom, $urandom});
    write_plane(SLOT_SPARE7, {$urandom, $urandom});
    end_config();
    run_random(150, 32767);
    settle();

    cube_planes($urandom_range(16, 400));
    run_random(100, 600);
    settle();

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_frustum_box_classifier: PASS");
    end else begin
      $display("tb_frustum_box_classifier: FAIL");
    end
    $finish;
  end

endmodule
